[rtl/core/rgbcc_pkg.sv]
// Package for the RGB color classifier: class codes, register indexes and
// constants. No dependencies.
`default_nettype none
package rgbcc_pkg;
	typedef enum logic [2:0] {
		CLS_UNDEF   = 3'd0,
		CLS_RED     = 3'd1,
		CLS_YELLOW  = 3'd2,
		CLS_GREEN   = 3'd3,
		CLS_CYAN    = 3'd4,
		CLS_BLUE    = 3'd5,
		CLS_MAGENTA = 3'd6,
		CLS_WHITE   = 3'd7
	} color_class_t;

	localparam logic [0:0] REG_DARK_LIMIT  = 1'b0;
	localparam logic [0:0] REG_WHITE_LIMIT = 1'b1;
	localparam int unsigned CFG_IDX_W = 8;

	localparam logic [7:0] DARK_LIMIT_RST  = 8'd51;
	localparam logic [7:0] WHITE_LIMIT_RST = 8'd230;

	// Number of bits in the divider numerator integer part: 360*diff fits 17 bits.
	localparam int unsigned NUM_W = 17;
endpackage
`default_nettype wire

[rtl/core/rgbcc_if.sv]
// Valid/ready stream interfaces for the RGB color classifier.
// Depends on no other file; field widths are written out.
`default_nettype none
interface rgbcc_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

interface rgbcc_hsv_if;
	logic        valid;
	logic        ready;
	logic [14:0] hue;
	logic [7:0]  saturation;
	logic [7:0]  brightness;
	logic [2:0]  color_class;
	modport source (output valid, hue, saturation, brightness, color_class, input ready);
	modport sink (input valid, hue, saturation, brightness, color_class, output ready);
endinterface

interface rgbcc_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] index;
	logic [7:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/core/rgbcc_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on nothing but its parameters; carries a sideband payload.
`default_nettype none
module rgbcc_div #(
	parameter int unsigned QW = 8,   // quotient bits
	parameter int unsigned DW = 8,   // divisor bits
	parameter int unsigned SW = 1    // sideband bits
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire logic [QW+DW-1:0]    in_num,
	input  wire logic [DW-1:0]       in_den,
	input  wire logic [SW-1:0]       in_side,
	output logic                     out_valid,
	output logic [QW-1:0]            out_quo,
	output logic [SW-1:0]            out_side
);
	// The numerator is below den << QW, so the quotient fits QW bits and
	// each partial remainder fits DW bits.
	logic [QW:0]              v_s;
	logic [QW:0][QW+DW-1:0]   n_s;
	logic [QW:0][DW-1:0]      d_s;
	logic [QW:0][SW-1:0]      x_s;

	assign v_s[0] = in_valid;
	assign n_s[0] = in_num;
	assign d_s[0] = in_den;
	assign x_s[0] = in_side;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW:0]       top;
		logic [DW:0]       trial;
		logic              fits;
		logic [QW+DW-1:0]  nxt;
		always_comb begin
			top   = n_s[k][QW+DW-1:QW-1];
			trial = top - {1'b0, d_s[k]};
			fits  = !trial[DW];
			nxt   = {n_s[k][QW+DW-2:0], fits};
			if (fits) nxt[QW+DW-1:QW] = trial[DW-1:0];
		end
		logic              v_r;
		logic [QW+DW-1:0]  n_r;
		logic [DW-1:0]     d_r;
		logic [SW-1:0]     x_r;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_r <= 1'b0;
			end else if (en) begin
				v_r <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				n_r <= nxt;
				d_r <= d_s[k];
				x_r <= x_s[k];
			end
		end
		assign v_s[k+1] = v_r;
		assign n_s[k+1] = n_r;
		assign d_s[k+1] = d_r;
		assign x_s[k+1] = x_r;
	end

	assign out_valid = v_s[QW];
	assign out_quo   = n_s[QW][QW-1:0];
	assign out_side  = x_s[QW];
endmodule
`default_nettype wire

[rtl/core/rgb_color_classifier.sv]
// RGB to HSV conversion and color classification, fully pipelined.
// Registers from input transfer to result: stage 1, stage 2, the hue divider stages, the output stage.
// Throughput: one sample per cycle unless the output stalls; set by the bit-per-stage hue divider.
// A stall freezes the whole pipeline; input ready follows the output slot combinationally.
// Reset clears all valid bits and loads the limits with 51 and 230.
// Depends on rgbcc_pkg, rgbcc_if and rgbcc_div.
`default_nettype none
module rgb_color_classifier
	import rgbcc_pkg::*;
#(
	parameter int unsigned HUE_FRAC_BITS = 6
) (
	input wire logic    clk,
	input wire logic    arst_n,
	rgbcc_cfg_if.sink   cfg,
	rgbcc_pix_if.sink   pix,
	rgbcc_hsv_if.source hsv
);
	localparam int unsigned QW = NUM_W + HUE_FRAC_BITS;
	localparam int unsigned HW = 15;
	localparam int unsigned SW = 8 + 8 + 1 + 1; // max, diff, dark, white

	logic [7:0] dark_q, white_q;
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dark_q  <= DARK_LIMIT_RST;
			white_q <= WHITE_LIMIT_RST;
		end else if (cfg.valid) begin
			if (cfg.index == {{(CFG_IDX_W-1){1'b0}}, REG_DARK_LIMIT})  dark_q  <= cfg.data;
			if (cfg.index == {{(CFG_IDX_W-1){1'b0}}, REG_WHITE_LIMIT}) white_q <= cfg.data;
		end
	end

	// Pipeline enable: advance when the output slot is free or being taken.
	logic en;
	assign en = !hsv.valid || hsv.ready;
	assign pix.ready = en;

	// Stage 1: max, min, hexcone numerator.
	logic        v_s1;
	logic [7:0]  mx_s1, diff_s1;
	logic [NUM_W-1:0] num_s1;
	logic [7:0] r0, g0, b0, mx0, mn0, d0;
	logic [NUM_W-1:0] num0;
	always_comb begin
		r0 = pix.red; g0 = pix.green; b0 = pix.blue;
		mx0 = r0;
		if (g0 > mx0) mx0 = g0;
		if (b0 > mx0) mx0 = b0;
		mn0 = r0;
		if (g0 < mn0) mn0 = g0;
		if (b0 < mn0) mn0 = b0;
		d0 = mx0 - mn0;
		if (mx0 == r0)
			num0 = NUM_W'(360 * 32'(d0) + 60 * 32'(g0) - 60 * 32'(b0));
		else if (mx0 == g0)
			num0 = NUM_W'(120 * 32'(d0) + 60 * 32'(b0) - 60 * 32'(r0));
		else
			num0 = NUM_W'(240 * 32'(d0) + 60 * 32'(r0) - 60 * 32'(g0));
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= pix.valid;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1 <= mx0; diff_s1 <= d0; num_s1 <= num0;
		end
	end

	// Stage 2: saturation product and class flags; divider operands.
	logic        v_s2;
	logic [7:0]  mx_s2, diff_s2;
	logic [15:0] satn_s2;
	logic [NUM_W-1:0] num_s2;
	logic        dark_s2, white_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			mx_s2    <= mx_s1;
			diff_s2  <= diff_s1;
			satn_s2  <= {diff_s1, 8'b0} - {8'b0, diff_s1};
			num_s2   <= num_s1;
			dark_s2  <= mx_s1 < dark_q;
			white_s2 <= ({2'b0, diff_s1} << 2) < {2'b0, mx_s1} && mx_s1 >= white_q;
		end
	end

	// Saturation divider runs alongside the hue divider, eight stages, then
	// its result waits in a delay line to match the longer hue divider.
	// A black sample divides by zero, so its flag rides along to clear it.
	logic        sv;
	logic [7:0]  sq;
	logic [0:0]  sx;
	rgbcc_div #(.QW(8), .DW(8), .SW(1)) u_sat (
		.clk, .arst_n, .en,
		.in_valid(v_s2), .in_num(satn_s2), .in_den(mx_s2), .in_side(mx_s2 == 8'd0),
		.out_valid(sv), .out_quo(sq), .out_side(sx)
	);
	logic [7:0]         sat0;
	logic [QW-9:0][7:0] satd_q;
	logic [QW-9:0]      svd_q;
	assign sat0 = sx[0] ? 8'd0 : sq;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) svd_q <= '0;
		else if (en) svd_q <= {svd_q[QW-10:0], sv};
	end
	always_ff @(posedge clk) begin
		if (en) satd_q <= {satd_q[QW-10:0], sat0};
	end

	logic        hv;
	logic [QW-1:0] hq;
	logic [SW-1:0] hx;
	rgbcc_div #(.QW(QW), .DW(8), .SW(SW)) u_hue (
		.clk, .arst_n, .en,
		.in_valid(v_s2), .in_num({8'b0, num_s2, {HUE_FRAC_BITS{1'b0}}}), .in_den(diff_s2),
		.in_side({mx_s2, diff_s2, dark_s2, white_s2}),
		.out_valid(hv), .out_quo(hq), .out_side(hx)
	);

	// Output stage: wrap, class bands.
	localparam logic [QW-1:0] H360 = QW'(360) << HUE_FRAC_BITS;
	logic [QW-1:0] h;
	color_class_t  cls;
	always_comb begin
		h = (hx[9:2] == 8'd0) ? '0 : hq;
		if (h >= H360) h = h - H360;
		if (hx[1]) cls = CLS_UNDEF;
		else if (hx[0]) cls = CLS_WHITE;
		else if (h < (QW'(15) << HUE_FRAC_BITS) || h >= (QW'(345) << HUE_FRAC_BITS))
			cls = CLS_RED;
		else if (h >= (QW'(40) << HUE_FRAC_BITS) && h < (QW'(75) << HUE_FRAC_BITS))
			cls = CLS_YELLOW;
		else if (h >= (QW'(75) << HUE_FRAC_BITS) && h < (QW'(165) << HUE_FRAC_BITS))
			cls = CLS_GREEN;
		else if (h >= (QW'(165) << HUE_FRAC_BITS) && h < (QW'(195) << HUE_FRAC_BITS))
			cls = CLS_CYAN;
		else if (h >= (QW'(195) << HUE_FRAC_BITS) && h < (QW'(255) << HUE_FRAC_BITS))
			cls = CLS_BLUE;
		else if (h >= (QW'(285) << HUE_FRAC_BITS) && h < (QW'(345) << HUE_FRAC_BITS))
			cls = CLS_MAGENTA;
		else cls = CLS_UNDEF;
	end

	logic        out_v_q;
	logic [14:0] hue_q;
	logic [7:0]  sat_q, val_q;
	logic [2:0]  cls_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (en) out_v_q <= hv;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			hue_q <= h[HW-1:0];
			sat_q <= satd_q[QW-9];
			val_q <= hx[17:10];
			cls_q <= cls;
		end
	end
	assign hsv.valid       = out_v_q;
	assign hsv.hue         = hue_q;
	assign hsv.saturation  = sat_q;
	assign hsv.brightness  = val_q;
	assign hsv.color_class = cls_q;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hsv.valid && !hsv.ready |=> hsv.valid && $stable(hsv.hue) && $stable(hsv.color_class))
		else $error("result changed under stall");
	a_white_sat: assert property (@(posedge clk) disable iff (!arst_n)
		hsv.valid && hsv.color_class == CLS_WHITE |-> hsv.brightness >= 8'd1)
		else $error("white class with zero brightness");
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv.valid |-> {1'b0, hsv.hue} < 16'(H360))
		else $error("hue out of range");
	a_sat_align: assert property (@(posedge clk) disable iff (!arst_n)
		hv == svd_q[QW-9])
		else $error("saturation and hue pipelines out of step");
endmodule
`default_nettype wire
